[rtl/erfs_pkg.sv]
// ----------------------------------------------------------------------------
// Event record filter scan package
// Shared payload types, configuration bundle, command and status codes.
// ----------------------------------------------------------------------------
package erfs_pkg;

   // Default depth of the child process list.
   localparam int MAX_CHILDREN_DEFAULT = 16;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_OBJECT_TYPE_MASK = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EVENT_TYPE_MASK  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OBJECT_ID_MATCH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROCESS_ID_MATCH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_USER_ID_MATCH    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_LOWER       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_UPPER       = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_ID_LIMIT         = 3'd7;

   // Command codes of an input word.
   localparam logic [1:0] CMD_RESTART = 2'd0;
   localparam logic [1:0] CMD_ADD     = 2'd1;
   localparam logic [1:0] CMD_RECORD  = 2'd2;

   // Status codes of a result word.
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_SKIP  = 3'd1;
   localparam logic [2:0] ST_MATCH = 3'd2;
   localparam logic [2:0] ST_END   = 3'd3;
   localparam logic [2:0] ST_FULL  = 3'd4;

   // Input word.
   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] event_id;
      logic [63:0] event_time;
      logic [63:0] object_id;
      logic [31:0] process_id;
      logic [4:0]  object_kind;
      logic [4:0]  event_kind;
      logic [15:0] user_id;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] result_id;
   } rsp_type;

   // Search criteria held in the configuration registers.
   typedef struct packed {
      logic [31:0] object_type_mask;
      logic [31:0] event_type_mask;
      logic [63:0] object_id_match;
      logic [31:0] process_id_match;
      logic [15:0] user_id_match;
      logic [63:0] time_lower;
      logic [63:0] time_upper;
      logic [63:0] id_limit;
   } cfg_type;

   // Control from the top level to the child list.
   typedef struct packed {
      logic clear;
      logic add;
   } child_ctl_type;

   // Status from the child list.
   typedef struct packed {
      logic any;
      logic full;
      logic hit;
   } child_stat_type;

   // State updates decided by the judge for one word.
   typedef struct packed {
      logic        clear_list;
      logic        add_child;
      logic        clear_ended;
      logic        end_scan;
      logic        set_start;
      logic [63:0] start_value;
   } upd_type;

endpackage

[rtl/erfs_child_list.sv]
// ----------------------------------------------------------------------------
// Child process list
// Bounded list of child process ids with a fill count and a parallel
// compare of every filled entry against the process id of the held word.
// ----------------------------------------------------------------------------
module erfs_child_list #(
   parameter int MAX_CHILDREN = erfs_pkg::MAX_CHILDREN_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  erfs_pkg::child_ctl_type  ctl,
   input  logic [31:0]              add_pid,
   input  logic [31:0]              query_pid,
   output erfs_pkg::child_stat_type stat
);

   localparam int CNT_W = $clog2(MAX_CHILDREN + 1);
   localparam int IDX_W = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [31:0]      entry_ff [MAX_CHILDREN];
   logic             full;
   logic             hit;

   assign full = (count_ff == CNT_W'(MAX_CHILDREN));

   // Fill count: a restart empties the list, an add appends one entry unless the list is full.
   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.add && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Entry storage; entries above the fill count are never consulted.
   always_ff @(posedge clock) begin
      if (ctl.add && !ctl.clear && !full) begin
         entry_ff[count_ff[IDX_W-1:0]] <= add_pid;
      end
   end

   // Match array: every filled entry is compared at once.
   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < MAX_CHILDREN; i++) begin
         if ((CNT_W'(i) < count_ff) && (entry_ff[i] == query_pid)) begin
            hit = 1'b1;
         end
      end
   end

   assign stat.any  = (count_ff != '0);
   assign stat.full = full;
   assign stat.hit  = hit;

   // The fill count never runs past the list depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_CHILDREN))
      else $error("child list count exceeds depth");

   // A full list refuses further entries.
   assert property (@(posedge clock) disable iff (reset)
      full && !ctl.clear |=> count_ff == $past(count_ff))
      else $error("child list grew while full");

endmodule

[rtl/erfs_judge.sv]
// ----------------------------------------------------------------------------
// Record judge
// Decides the result word and the state updates for one held input word,
// checking the criteria in their fixed order.
// ----------------------------------------------------------------------------
module erfs_judge (
   input  erfs_pkg::req_type        req,
   input  erfs_pkg::cfg_type        cfg,
   input  erfs_pkg::child_stat_type child,
   input  logic                     scan_ended,
   input  logic [63:0]              scan_start,
   output erfs_pkg::upd_type        upd,
   output erfs_pkg::rsp_type        rsp
);

   logic [63:0] id;
   logic        type_ok;
   logic        event_ok;

   assign id       = req.event_id;
   assign type_ok  = (cfg.object_type_mask == '0) || cfg.object_type_mask[req.object_kind];
   assign event_ok = (cfg.event_type_mask == '0) || cfg.event_type_mask[req.event_kind];

   // Command dispatch and the ordered record checks.
   always_comb begin
      upd           = '0;
      rsp.status    = erfs_pkg::ST_SKIP;
      rsp.result_id = '0;
      case (req.cmd)
         erfs_pkg::CMD_RESTART: begin
            upd.clear_list  = 1'b1;
            upd.clear_ended = 1'b1;
            upd.set_start   = 1'b1;
            upd.start_value = (id != '0) ? id : 64'd1;
            rsp.status      = erfs_pkg::ST_OK;
         end
         erfs_pkg::CMD_ADD: begin
            if (child.full) begin
               rsp.status = erfs_pkg::ST_FULL;
            end else begin
               upd.add_child = 1'b1;
               rsp.status    = erfs_pkg::ST_OK;
            end
         end
         erfs_pkg::CMD_RECORD: begin
            rsp.result_id = id;
            if (scan_ended) begin
               rsp.status = erfs_pkg::ST_END;
            end else if (id < scan_start) begin
               rsp.status = erfs_pkg::ST_SKIP;
            end else if ((cfg.id_limit != '0) && (id >= cfg.id_limit)) begin
               upd.end_scan = 1'b1;
               rsp.status   = erfs_pkg::ST_END;
            end else if ((cfg.object_id_match != '0)
                         && (req.object_id != cfg.object_id_match)) begin
               rsp.status = erfs_pkg::ST_SKIP;
            end else if ((cfg.process_id_match != '0)
                         && (req.process_id != cfg.process_id_match)) begin
               rsp.status = erfs_pkg::ST_SKIP;
            end else if (child.any && !child.hit) begin
               rsp.status = erfs_pkg::ST_SKIP;
            end else if (!type_ok || !event_ok) begin
               rsp.status = erfs_pkg::ST_SKIP;
            end else if (req.event_time < cfg.time_lower) begin
               rsp.status = erfs_pkg::ST_SKIP;
            end else if ((cfg.time_upper != '0) && (req.event_time > cfg.time_upper)) begin
               upd.end_scan = 1'b1;
               rsp.status   = erfs_pkg::ST_END;
            end else if ((cfg.user_id_match != '0) && (req.user_id != cfg.user_id_match)) begin
               rsp.status = erfs_pkg::ST_SKIP;
            end else begin
               // A match at the largest id ends the scan, as no id can follow.
               rsp.status = erfs_pkg::ST_MATCH;
               if (id == '1) begin
                  upd.end_scan = 1'b1;
               end else begin
                  upd.set_start   = 1'b1;
                  upd.start_value = id + 64'd1;
               end
            end
         end
         default: begin
            rsp.status = erfs_pkg::ST_SKIP;
         end
      endcase
   end

endmodule

[rtl/event_record_filter_scan.sv]
// ----------------------------------------------------------------------------
// Event record filter scan
// Filters a stream of event records against a search held in registers.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  erfs_pkg::req_type
//   rsp_     out        rsp_valid / rsp_stall  erfs_pkg::rsp_type
//   csr_     in         csr_wr_en              csr_index, csr_wr_data
//
// One word is taken per cycle while req_stall is low; each produces exactly one result word.
// An input register holds the word, then the judge and child list
// compare feed the result register, where the scan state is updated.
// Reset clears the handshake, the fill count and the scan state (start id 1).
// A stalled result register holds the input register, which then stalls req_.
// ----------------------------------------------------------------------------
module event_record_filter_scan #(
   parameter int MAX_CHILDREN = erfs_pkg::MAX_CHILDREN_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  erfs_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output erfs_pkg::rsp_type                  rsp_data,
   input  logic                               csr_wr_en,
   input  logic [erfs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [erfs_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   logic                     stg_valid_ff;
   logic                     stg_valid_in;
   erfs_pkg::req_type        stg_req_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   erfs_pkg::rsp_type        rsp_data_ff;
   erfs_pkg::cfg_type        cfg_ff;
   logic                     scan_ended_ff;
   logic                     scan_ended_in;
   logic [63:0]              scan_start_ff;
   logic [63:0]              scan_start_in;
   logic                     accept;
   logic                     advance;
   erfs_pkg::upd_type        upd;
   erfs_pkg::rsp_type        judged;
   erfs_pkg::child_ctl_type  child_ctl;
   erfs_pkg::child_stat_type child_stat;

   // Handshake: the held word moves on when the result register is free.
   assign advance      = stg_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = stg_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign stg_valid_in = accept || (stg_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (accept) begin
         stg_req_ff <= req_data;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            erfs_pkg::CSR_OBJECT_TYPE_MASK: cfg_ff.object_type_mask <= csr_wr_data[31:0];
            erfs_pkg::CSR_EVENT_TYPE_MASK:  cfg_ff.event_type_mask  <= csr_wr_data[31:0];
            erfs_pkg::CSR_OBJECT_ID_MATCH:  cfg_ff.object_id_match  <= csr_wr_data;
            erfs_pkg::CSR_PROCESS_ID_MATCH: cfg_ff.process_id_match <= csr_wr_data[31:0];
            erfs_pkg::CSR_USER_ID_MATCH:    cfg_ff.user_id_match    <= csr_wr_data[15:0];
            erfs_pkg::CSR_TIME_LOWER:       cfg_ff.time_lower       <= csr_wr_data;
            erfs_pkg::CSR_TIME_UPPER:       cfg_ff.time_upper       <= csr_wr_data;
            erfs_pkg::CSR_ID_LIMIT:         cfg_ff.id_limit         <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // Child process list with its parallel compare.
   assign child_ctl.clear = advance && upd.clear_list;
   assign child_ctl.add   = advance && upd.add_child;

   erfs_child_list #(
      .MAX_CHILDREN (MAX_CHILDREN)
   ) u_child_list (
      .clock     (clock),
      .reset     (reset),
      .ctl       (child_ctl),
      .add_pid   (stg_req_ff.process_id),
      .query_pid (stg_req_ff.process_id),
      .stat      (child_stat)
   );

   // Judge for the held word.
   erfs_judge u_judge (
      .req        (stg_req_ff),
      .cfg        (cfg_ff),
      .child      (child_stat),
      .scan_ended (scan_ended_ff),
      .scan_start (scan_start_ff),
      .upd        (upd),
      .rsp        (judged)
   );

   // Scan state, updated as the word moves into the result register.
   always_comb begin
      scan_ended_in = scan_ended_ff;
      scan_start_in = scan_start_ff;
      if (advance) begin
         if (upd.clear_ended) begin
            scan_ended_in = 1'b0;
         end else if (upd.end_scan) begin
            scan_ended_in = 1'b1;
         end
         if (upd.set_start) begin
            scan_start_in = upd.start_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ended_ff <= 1'b0;
         scan_start_ff <= 64'd1;
      end else begin
         scan_ended_ff <= scan_ended_in;
         scan_start_ff <= scan_start_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= judged;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result appears only when a held word was moved on.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("result appeared without a word moving on");

   // A restart always reopens the scan.
   assert property (@(posedge clock) disable iff (reset)
      advance && (stg_req_ff.cmd == erfs_pkg::CMD_RESTART) |=> !scan_ended_ff)
      else $error("scan still ended after restart");

   // Once the scan has ended, every record reports the end.
   assert property (@(posedge clock) disable iff (reset)
      advance && scan_ended_ff && (stg_req_ff.cmd == erfs_pkg::CMD_RECORD)
      |=> rsp_data_ff.status == erfs_pkg::ST_END)
      else $error("record judged after the scan ended");

   // A match that does not end the scan moves the start past the matched id.
   assert property (@(posedge clock) disable iff (reset)
      advance && (judged.status == erfs_pkg::ST_MATCH) && !upd.end_scan
      |=> scan_start_ff == $past(stg_req_ff.event_id) + 64'd1)
      else $error("start id not advanced after a match");

endmodule
